// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/rmsn_pkg.sv -----
`default_nettype none
package rmsn_pkg;
	localparam int unsigned MaxHidden = 4096;
	localparam int unsigned CountMax = 8191;
	localparam int unsigned Limit = (MaxHidden > CountMax) ? CountMax : MaxHidden;
	localparam int unsigned SumW = 43;
	localparam int unsigned CntW = 13;
	localparam int unsigned InvW = 32;
	localparam int unsigned EpsW = 30;
	localparam int unsigned EpsReset = 17;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic acc;       // accumulate the input word's square
		logic div_start; // load divider for mean square
		logic div_step;  // one divider step
		logic sqrt_start;
		logic sqrt_step;
		logic inv_start;
		logic inv_step;
		logic fin;       // store inverse rms, clear row state
		logic mul1;      // value times weight stage
		logic mul2;      // magnitude times inverse rms
		logic rnd;       // round and saturate into output register
	} rmsn_cmd_t;
endpackage
`default_nettype wire

// ----- hw/rtl/rmsn_datapath.sv -----
`default_nettype none
module rmsn_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rmsn_pkg::rmsn_cmd_t       cmd,
	input  wire logic [15:0]               value,
	input  wire logic [15:0]               weight,
	input  wire logic [rmsn_pkg::EpsW-1:0] epsilon,
	output logic [15:0]                    normalized,
	output logic                           saturated,
	output logic                           row_too_long
);
	import rmsn_pkg::*;

	logic [SumW-1:0] sum_q;
	logic [CntW-1:0] cnt_q;
	logic [InvW-1:0] inv_q;
	logic            ovf_q;
	// Shared restoring shift-subtract registers.
	logic [63:0]     rem_q;
	logic [63:0]     quo_q;
	logic [63:0]     num_q;
	logic [52:0]     den_q;
	logic [63:0]     root_q;
	logic [4:0]      step_q;
	logic [31:0]     vw_s1;
	logic            neg_s1;
	logic [63:0]     prod_s2;
	logic            neg_s2;

	logic [31:0] sq;
	logic [SumW:0] sum_nx;
	logic [31:0] vw;
	logic [31:0] mag;
	logic [63:0] r;
	logic [64:0] rq;

	always_comb begin
		sq = 32'($signed(value) * $signed(value));
		sum_nx = {1'b0, sum_q} + {{(SumW+1-32){1'b0}}, sq};
		vw = 32'($signed(value) * $signed(weight));
		mag = vw[31] ? (32'd0 - vw) : vw;
		rq = {1'b0, prod_s2} + (65'd1 << 37);
		r = 64'(rq >> 38);
	end

	// Square root search: root_q holds the partial result, rem_q the radicand.
	logic [63:0] sq_bit;
	logic [64:0] sq_try;
	logic [63:0] num_sh;
	assign sq_bit = 64'd1 << {step_q, 1'b0};
	assign sq_try = {1'b0, rem_q} - {1'b0, root_q} - {1'b0, sq_bit};
	assign num_sh = {num_q[62:0], 1'b0};

	logic [64:0] dtry;
	assign dtry = {1'b0, rem_q[62:0], num_q[63]} - {12'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			inv_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.acc) begin
				if (32'(cnt_q) < Limit) begin
					sum_q <= sum_nx[SumW] ? {SumW{1'b1}} : sum_nx[SumW-1:0];
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '0) ovf_q <= 1'b0;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.fin) begin
				sum_q <= '0;
				cnt_q <= '0;
				if (root_q == '0 || quo_q[63:32] != '0) inv_q <= '1;
				else inv_q <= quo_q[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			num_q <= {21'd0, sum_q};
			den_q <= {40'd0, cnt_q};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= num_sh;
			if (!dtry[64]) begin
				rem_q <= dtry[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], num_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end else if (cmd.sqrt_start) begin
			// Empty row gives mean zero.
			rem_q <= {(((cnt_q == '0) ? 32'd0 : quo_q[31:0]) + {2'd0, epsilon}), 32'd0};
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			if (!sq_try[64]) begin
				rem_q <= sq_try[63:0];
				root_q <= (root_q >> 1) + sq_bit;
			end else begin
				root_q <= root_q >> 1;
			end
		end else if (cmd.inv_start) begin
			rem_q <= '0;
			num_q <= 64'd1 << 52;
			den_q <= {21'd0, root_q[31:0]};
			quo_q <= '0;
		end else if (cmd.inv_step) begin
			num_q <= num_sh;
			if (!dtry[64]) begin
				rem_q <= dtry[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], num_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
		if (cmd.sqrt_start) step_q <= 5'd31;
		else if (cmd.sqrt_step) step_q <= step_q - 1'b1;
		if (cmd.mul1) begin
			vw_s1 <= mag;
			neg_s1 <= vw[31];
		end
		if (cmd.mul2) begin
			prod_s2 <= {32'd0, vw_s1} * {32'd0, inv_q};
			neg_s2 <= neg_s1;
		end
		if (cmd.rnd) begin
			row_too_long <= ovf_q;
			if (neg_s2) begin
				saturated <= r > 64'd32768;
				normalized <= (r > 64'd32768) ? 16'h8000 : 16'(64'd0 - r);
			end else begin
				saturated <= r > 64'd32767;
				normalized <= (r > 64'd32767) ? 16'h7fff : r[15:0];
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/rmsn_ctrl.sv -----
`default_nettype none
module rmsn_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_fire,
	input  wire logic          mode,
	input  wire logic          last,
	input  wire logic          out_free,
	output logic               busy,
	output logic               out_load,
	output rmsn_pkg::rmsn_cmd_t cmd
);
	import rmsn_pkg::*;

	typedef enum logic [3:0] {
		IDLE, DIV, SQRT0, SQRT, INV0, INV, FIN, MUL2, RND
	} state_t;

	state_t    state_q;
	logic [6:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: if (in_fire) begin
					if (mode) state_q <= MUL2;
					else if (last) begin
						state_q <= DIV;
						cnt_q <= 7'd64;
					end
				end
				DIV: if (cnt_q == 7'd0) state_q <= SQRT0;
				else cnt_q <= cnt_q - 1'b1;
				SQRT0: begin
					state_q <= SQRT;
					cnt_q <= 7'd31;
				end
				SQRT: if (cnt_q == 7'd0) state_q <= INV0;
				else cnt_q <= cnt_q - 1'b1;
				INV0: begin
					state_q <= INV;
					cnt_q <= 7'd63;
				end
				INV: if (cnt_q == 7'd0) state_q <= FIN;
				else cnt_q <= cnt_q - 1'b1;
				FIN: state_q <= IDLE;
				MUL2: state_q <= RND;
				RND: if (out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.acc = in_fire && !mode;
		cmd.mul1 = in_fire && mode;
		// The divider is loaded in the cycle after the last word, once its square is summed.
		cmd.div_start = (state_q == DIV) && (cnt_q == 7'd64);
		cmd.div_step = (state_q == DIV) && (cnt_q != 7'd64);
		cmd.sqrt_start = state_q == SQRT0;
		cmd.sqrt_step = state_q == SQRT;
		cmd.inv_start = state_q == INV0;
		cmd.inv_step = state_q == INV;
		cmd.fin = state_q == FIN;
		cmd.mul2 = state_q == MUL2;
		cmd.rnd = (state_q == RND) && out_free;
		out_load = cmd.rnd;
		busy = state_q != IDLE;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/rms_normalization_top.sv -----
`default_nettype none
// RMS normalization of one row at a time, in fixed point.
// Input words arrive on the s_axis channel. A row is sent twice: first in
// accumulate mode (tuser = 0), where each word adds its square to a running
// sum, then in apply mode (tuser = 1) with weights, where each word yields
// one result word on m_axis. Accumulate words give no result.
// The accumulate word marked last starts the finish step: a divider load, a
// 64-step divide, a 32-step square root and a 64-step reciprocal on one
// shift-subtract unit, after which the inverse rms is stored.
// An apply word passes through two multiply stages and a rounding stage;
// the result then sits in an output register.
// The output register is loaded only when empty or being taken, so a stall
// on m_axis holds the controller in its rounding state until room appears.
// Epsilon is written on the cfg channel, whose ready is low while busy.
// Reset clears sum, count, inverse rms, overflow and valid flags; epsilon is 17.
`include "assert_macros.svh"
module rms_normalization_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [29:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // value [15:0], weight [31:16]
	input  wire logic        s_axis_tuser,  // mode
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // normalized [15:0], saturated [16], row_too_long [17]
	output logic             m_axis_tlast
);
	import rmsn_pkg::*;

	logic            busy;
	logic            out_load;
	logic            in_fire;
	logic            last_s1;
	logic [EpsW-1:0] eps_q;
	rmsn_cmd_t       cmd;
	logic [15:0]     norm;
	logic            sat;
	logic            rtl_flag;
	logic            vld_q;
	logic            out_free;

	assign cfg_ready = !busy;
	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EpsW'(EpsReset);
			vld_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) eps_q <= cfg_data;
			if (out_load) vld_q <= 1'b1;
			else if (m_axis_tready) vld_q <= 1'b0;
		end
	end

	// The last marker of an apply word travels with it to the output.
	always_ff @(posedge clk) begin
		if (in_fire) last_s1 <= s_axis_tlast;
		if (out_load) m_axis_tlast <= last_s1;
	end

	rmsn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .mode(s_axis_tuser),
		.last(s_axis_tlast), .out_free(out_free), .busy(busy),
		.out_load(out_load), .cmd(cmd)
	);

	rmsn_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .value(s_axis_tdata[15:0]),
		.weight(s_axis_tdata[31:16]), .epsilon(eps_q), .normalized(norm),
		.saturated(sat), .row_too_long(rtl_flag)
	);

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = {6'd0, rtl_flag, sat, norm};

	`ASSERT_IMPLY(a_no_in_busy, clk, arst_n, busy, !s_axis_tready)
	`ASSERT_IMPLY(a_load_room, clk, arst_n, out_load, out_free)
	`ASSERT_NEXT(a_load_valid, clk, arst_n, out_load, m_axis_tvalid)
endmodule
`default_nettype wire
